[hw/rtl/hbtm_pkg.sv]
// Shared types and constants of the Hamming best-two matcher.
// Used by the matcher, its port checker and the benches; depends on nothing.
package hbtm_pkg;

  localparam int INDEX_BITS     = 12;
  localparam int DESC_BITS      = 256;
  localparam int WORD_BITS      = 64;
  localparam int DIST_BITS      = $clog2(DESC_BITS + 1);
  localparam int LEVEL_BITS     = 3;
  // A stored level carries one bit more so that it can say "no level".
  localparam int SLVL_BITS      = LEVEL_BITS + 1;
  localparam int RATIO_FRAC     = 8;
  localparam int CFG_DATA_BITS  = 9;
  localparam int CFG_INDEX_BITS = 2;
  localparam int MODE_BITS      = 2;

  localparam logic [DIST_BITS-1:0] NO_DIST  = DIST_BITS'(DESC_BITS);
  localparam logic [SLVL_BITS-1:0] NO_LEVEL = SLVL_BITS'(1 << LEVEL_BITS);

  localparam logic [DIST_BITS-1:0] THRESHOLD_RESET = DIST_BITS'(50);
  localparam logic [DIST_BITS-1:0] RATIO_RESET     = DIST_BITS'(154);

  localparam logic [MODE_BITS-1:0] MODE_VOCAB = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_PROJ  = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_BEST  = 2'd2;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_MATCH_MODE = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_THRESHOLD  = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_RATIO      = 2'd2;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_CAND = 1'b1;

  typedef struct packed {
    logic                  op;
    logic [WORD_BITS-1:0]  desc_word0;
    logic [WORD_BITS-1:0]  desc_word1;
    logic [WORD_BITS-1:0]  desc_word2;
    logic [WORD_BITS-1:0]  desc_word3;
    logic [INDEX_BITS-1:0] cand_index;
    logic [LEVEL_BITS-1:0] cand_level;
    logic                  cand_excluded;
    logic                  last;
  } req_t;

  typedef struct packed {
    logic                  matched;
    logic [INDEX_BITS-1:0] best_index;
    logic [DIST_BITS-1:0]  best_distance;
    logic [DIST_BITS-1:0]  second_distance;
  } res_t;

endpackage

[hw/rtl/hamming_best_two_matcher.sv]
// Hamming best-two matcher: popcount search, verdict stage and register file.
// Depends on hbtm_pkg.
//
// The block takes one item per clock cycle, but stalls a last candidate while
// the verdict stage is full. A query item loads the 256-bit descriptor and
// restarts the search; each candidate item is XORed with the query, its
// population count is taken and compared with the best and second-best
// distances, all in the cycle after it is accepted. That popcount and compare
// loop sets the rate of one item a cycle. A candidate flagged last sends its
// search result to a verdict stage, where the ratio product and threshold
// tests are applied, and the verdict is registered on the result channel.
// Configuration should be written only while no item is in flight.
module hamming_best_two_matcher (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                req_valid,
  output logic                                req_stall,
  input  hbtm_pkg::req_t                      req,
  output logic                                res_valid,
  input  logic                                res_stall,
  output hbtm_pkg::res_t                      res,
  input  logic                                cfg_we,
  input  logic [hbtm_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [hbtm_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  typedef struct packed {
    logic                                found;
    logic [hbtm_pkg::DIST_BITS-1:0]      best;
    logic [hbtm_pkg::DIST_BITS-1:0]      second;
    logic [hbtm_pkg::INDEX_BITS-1:0]     idx;
    logic [hbtm_pkg::SLVL_BITS-1:0]      best_lvl;
    logic [hbtm_pkg::SLVL_BITS-1:0]      second_lvl;
  } srch_t;

  localparam srch_t SRCH_CLEAR = '{
    found:      1'b0,
    best:       hbtm_pkg::NO_DIST,
    second:     hbtm_pkg::NO_DIST,
    idx:        '0,
    best_lvl:   hbtm_pkg::NO_LEVEL,
    second_lvl: hbtm_pkg::NO_LEVEL
  };

  localparam int PROD_BITS = 2 * hbtm_pkg::DIST_BITS;

  // Adder tree over the 256 bits, eight levels of independent pair sums.
  function automatic logic [hbtm_pkg::DIST_BITS-1:0] ones256(
    input logic [hbtm_pkg::DESC_BITS-1:0] v
  );
    logic [1:0] l1 [128];
    logic [2:0] l2 [64];
    logic [3:0] l3 [32];
    logic [4:0] l4 [16];
    logic [5:0] l5 [8];
    logic [6:0] l6 [4];
    logic [7:0] l7 [2];
    for (int i = 0; i < 128; i++) begin
      l1[i] = {1'b0, v[2*i]} + {1'b0, v[2*i+1]};
    end
    for (int i = 0; i < 64; i++) begin
      l2[i] = {1'b0, l1[2*i]} + {1'b0, l1[2*i+1]};
    end
    for (int i = 0; i < 32; i++) begin
      l3[i] = {1'b0, l2[2*i]} + {1'b0, l2[2*i+1]};
    end
    for (int i = 0; i < 16; i++) begin
      l4[i] = {1'b0, l3[2*i]} + {1'b0, l3[2*i+1]};
    end
    for (int i = 0; i < 8; i++) begin
      l5[i] = {1'b0, l4[2*i]} + {1'b0, l4[2*i+1]};
    end
    for (int i = 0; i < 4; i++) begin
      l6[i] = {1'b0, l5[2*i]} + {1'b0, l5[2*i+1]};
    end
    for (int i = 0; i < 2; i++) begin
      l7[i] = {1'b0, l6[2*i]} + {1'b0, l6[2*i+1]};
    end
    return {1'b0, l7[0]} + {1'b0, l7[1]};
  endfunction

  // Configuration registers.
  logic [hbtm_pkg::MODE_BITS-1:0] match_mode;
  logic [hbtm_pkg::DIST_BITS-1:0] dist_threshold;
  logic [hbtm_pkg::DIST_BITS-1:0] ratio_q8;

  // Search state.
  logic [hbtm_pkg::DESC_BITS-1:0] query_desc;
  srch_t                          srch;
  srch_t                          srch_next;

  // Input register and verdict stage.
  logic           s1_valid;
  hbtm_pkg::req_t s1_item;
  logic           s2_valid;
  srch_t          s2_srch;

  logic                           out_free;
  logic                           s2_free;
  logic                           s1_is_last;
  logic                           s1_go;
  logic                           s1_counted;
  logic [hbtm_pkg::DESC_BITS-1:0] s1_desc;
  logic [hbtm_pkg::DIST_BITS-1:0] cand_dist;
  logic [PROD_BITS-1:0]           lhs;
  logic [PROD_BITS-1:0]           rhs;
  logic                           verdict;

  assign out_free   = !res_valid || !res_stall;
  assign s2_free    = !s2_valid || out_free;
  assign s1_is_last = (s1_item.op == hbtm_pkg::OP_CAND) && s1_item.last;
  assign s1_go      = s1_valid && (!s1_is_last || s2_free);
  assign req_stall  = s1_valid && !s1_go;

  assign s1_desc   = {s1_item.desc_word3, s1_item.desc_word2,
                      s1_item.desc_word1, s1_item.desc_word0};
  assign cand_dist = ones256(query_desc ^ s1_desc);

  assign s1_counted = (s1_item.op == hbtm_pkg::OP_CAND) && !s1_item.cand_excluded;

  // A distance equal to the best only competes for second place.
  always_comb begin
    srch_next = srch;
    if (s1_counted) begin
      srch_next.found = 1'b1;
      if (cand_dist < srch.best) begin
        srch_next.second     = srch.best;
        srch_next.second_lvl = srch.best_lvl;
        srch_next.best       = cand_dist;
        srch_next.best_lvl   = {1'b0, s1_item.cand_level};
        srch_next.idx        = s1_item.cand_index;
      end else if (cand_dist < srch.second) begin
        srch_next.second     = cand_dist;
        srch_next.second_lvl = {1'b0, s1_item.cand_level};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      match_mode     <= hbtm_pkg::MODE_VOCAB;
      dist_threshold <= hbtm_pkg::THRESHOLD_RESET;
      ratio_q8       <= hbtm_pkg::RATIO_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        hbtm_pkg::CFG_MATCH_MODE: match_mode     <= cfg_data[hbtm_pkg::MODE_BITS-1:0];
        hbtm_pkg::CFG_THRESHOLD:  dist_threshold <= cfg_data[hbtm_pkg::DIST_BITS-1:0];
        hbtm_pkg::CFG_RATIO:      ratio_q8       <= cfg_data[hbtm_pkg::DIST_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!req_stall) begin
      s1_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      s1_item <= req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      query_desc <= '0;
      srch       <= SRCH_CLEAR;
    end else if (s1_go) begin
      if (s1_item.op == hbtm_pkg::OP_LOAD) begin
        query_desc <= s1_desc;
        srch       <= SRCH_CLEAR;
      end else if (s1_item.last) begin
        srch <= SRCH_CLEAR;
      end else begin
        srch <= srch_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s1_go && s1_is_last) begin
      s2_valid <= 1'b1;
    end else if (out_free) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_is_last) begin
      s2_srch <= srch_next;
    end
  end

  assign lhs = PROD_BITS'(s2_srch.best) << hbtm_pkg::RATIO_FRAC;
  assign rhs = PROD_BITS'(ratio_q8) * PROD_BITS'(s2_srch.second);

  always_comb begin
    verdict = 1'b0;
    if (s2_srch.found) begin
      case (match_mode)
        hbtm_pkg::MODE_VOCAB: verdict = (s2_srch.best <= dist_threshold) && (lhs < rhs);
        hbtm_pkg::MODE_PROJ: begin
          verdict = (s2_srch.best <= dist_threshold) &&
                    !((s2_srch.best_lvl == s2_srch.second_lvl) && (lhs > rhs));
        end
        hbtm_pkg::MODE_BEST:  verdict = s2_srch.best < dist_threshold;
        default:              verdict = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_free) begin
      res_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s2_valid) begin
      res.matched         <= verdict;
      res.best_index      <= s2_srch.idx;
      res.best_distance   <= s2_srch.best;
      res.second_distance <= s2_srch.second;
    end
  end

endmodule

[hw/rtl/hbtm_checker.sv]
// Port-level checks of the Hamming best-two matcher, attached by bind.
// Depends on hbtm_pkg and on the top level hamming_best_two_matcher.
module hbtm_port_checker (
  input logic           clk,
  input logic           rst,
  input logic           res_valid,
  input logic           res_stall,
  input hbtm_pkg::res_t res
);

  // A result held back by the receiver stays put.
  assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res))
    else $error("stalled result item changed or was dropped");

  // The second-best distance can never be below the best one.
  assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res.best_distance <= res.second_distance)
    else $error("second distance below best distance");

  // With no distance below the empty mark the search never took an index.
  assert property (@(posedge clk) disable iff (rst)
    res_valid && (res.best_distance == hbtm_pkg::NO_DIST) |->
      (res.best_index == '0) && (res.second_distance == hbtm_pkg::NO_DIST))
    else $error("empty search reported an index or a second distance");

  // The cycle after reset shows no result.
  assert property (@(posedge clk) $past(rst) |-> !res_valid)
    else $error("result item shown straight after reset");

endmodule

bind hamming_best_two_matcher hbtm_port_checker u_hbtm_checker (.*);

[sim/hbtm_checker.sv]
`timescale 1ns / 100ps
// Verdict checker for the Hamming best-two matcher: watches the item, result and
// register ports, keeps its own search state and compares every verdict.
// Depends on hbtm_pkg.
module hbtm_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                req_valid,
  input  logic                                req_stall,
  input  hbtm_pkg::req_t                      req,
  input  logic                                res_valid,
  input  logic                                res_stall,
  input  hbtm_pkg::res_t                      res,
  input  logic                                cfg_we,
  input  logic [hbtm_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [hbtm_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  output int                                  fail_count,
  output int                                  open_count,
  output int                                  result_count
);

  localparam int REPORT_LIMIT = 10;

  logic [hbtm_pkg::DESC_BITS-1:0]     query_bits;
  logic [hbtm_pkg::DIST_BITS-1:0]     near_dist;
  logic [hbtm_pkg::DIST_BITS-1:0]     runner_dist;
  logic [hbtm_pkg::INDEX_BITS-1:0]    near_index;
  logic [hbtm_pkg::SLVL_BITS-1:0]     near_level;
  logic [hbtm_pkg::SLVL_BITS-1:0]     runner_level;
  logic                               any_counted;
  logic [hbtm_pkg::MODE_BITS-1:0]     mode_r;
  logic [hbtm_pkg::CFG_DATA_BITS-1:0] limit_r;
  logic [hbtm_pkg::CFG_DATA_BITS-1:0] ratio_r;
  hbtm_pkg::res_t                     expected_verdicts[$];
  int                                 fails;
  int                                 checked;

  task automatic clear_search();
    near_dist    = hbtm_pkg::NO_DIST;
    runner_dist  = hbtm_pkg::NO_DIST;
    near_index   = '0;
    any_counted  = 1'b0;
    near_level   = hbtm_pkg::NO_LEVEL;
    runner_level = hbtm_pkg::NO_LEVEL;
  endtask

  function automatic logic judge();
    int unsigned scaled_near;
    int unsigned scaled_runner;
    scaled_near   = 32'(near_dist) << hbtm_pkg::RATIO_FRAC;
    scaled_runner = 32'(ratio_r) * 32'(runner_dist);
    if (!any_counted) return 1'b0;
    case (mode_r)
      hbtm_pkg::MODE_VOCAB: begin
        return (near_dist <= limit_r) && (scaled_near < scaled_runner);
      end
      // The ratio only applies when both candidates come from the same octave.
      hbtm_pkg::MODE_PROJ: begin
        return (near_dist <= limit_r) &&
               !((near_level == runner_level) && (scaled_near > scaled_runner));
      end
      hbtm_pkg::MODE_BEST: return near_dist < limit_r;
      default: return 1'b0;
    endcase
  endfunction

  task automatic take_item(input hbtm_pkg::req_t it);
    logic [hbtm_pkg::DESC_BITS-1:0] cand_bits;
    logic [hbtm_pkg::DIST_BITS-1:0] cand_dist;
    hbtm_pkg::res_t                 verdict;
    cand_bits = {it.desc_word3, it.desc_word2, it.desc_word1, it.desc_word0};
    if (it.op == hbtm_pkg::OP_LOAD) begin
      query_bits = cand_bits;
      clear_search();
    end else begin
      if (!it.cand_excluded) begin
        cand_dist = hbtm_pkg::DIST_BITS'($countones(query_bits ^ cand_bits));
        any_counted = 1'b1;
        if (cand_dist < near_dist) begin
          runner_dist  = near_dist;
          runner_level = near_level;
          near_dist    = cand_dist;
          near_level   = {1'b0, it.cand_level};
          near_index   = it.cand_index;
        end else if (cand_dist < runner_dist) begin
          runner_dist  = cand_dist;
          runner_level = {1'b0, it.cand_level};
        end
      end
      if (it.last) begin
        verdict.matched         = judge();
        verdict.best_index      = near_index;
        verdict.best_distance   = near_dist;
        verdict.second_distance = runner_dist;
        expected_verdicts = {expected_verdicts, verdict};
        clear_search();
      end
    end
  endtask

  task automatic check_verdict(input hbtm_pkg::res_t got);
    hbtm_pkg::res_t want;
    if (expected_verdicts.size() == 0) begin
      fails++;
      if (fails <= REPORT_LIMIT) begin
        $display("[%0t] verdict with none expected: matched=%0d index=%0d best=%0d second=%0d",
                 $realtime, got.matched, got.best_index, got.best_distance,
                 got.second_distance);
      end
    end else begin
      want = expected_verdicts.pop_front();
      checked++;
      if (got.matched !== want.matched || got.best_index !== want.best_index ||
          got.best_distance !== want.best_distance ||
          got.second_distance !== want.second_distance) begin
        fails++;
        if (fails <= REPORT_LIMIT) begin
          $display("[%0t] verdict %0d wrong: expected matched=%0d index=%0d",
                   $realtime, checked, want.matched, want.best_index);
          $display("[%0t]   expected best=%0d second=%0d",
                   $realtime, want.best_distance, want.second_distance);
          $display("[%0t]   got matched=%0d index=%0d best=%0d second=%0d",
                   $realtime, got.matched, got.best_index, got.best_distance,
                   got.second_distance);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      query_bits = '0;
      mode_r     = hbtm_pkg::MODE_VOCAB;
      limit_r    = hbtm_pkg::THRESHOLD_RESET;
      ratio_r    = hbtm_pkg::RATIO_RESET;
      clear_search();
      expected_verdicts.delete();
    end else begin
      // A result leaves only after its item has passed the block's registers, so check before predicting.
      if (res_valid && !res_stall) check_verdict(res);
      if (cfg_we) begin
        case (cfg_index)
          hbtm_pkg::CFG_MATCH_MODE: mode_r  = cfg_data[hbtm_pkg::MODE_BITS-1:0];
          hbtm_pkg::CFG_THRESHOLD:  limit_r = cfg_data;
          hbtm_pkg::CFG_RATIO:      ratio_r = cfg_data;
          default: ;
        endcase
      end
      if (req_valid && !req_stall) take_item(req);
    end
    fail_count   <= fails;
    open_count   <= expected_verdicts.size();
    result_count <= checked;
  end

endmodule

[sim/tb_hamming_best_two_matcher.sv]
`timescale 1ns / 100ps
// Testbench top for the Hamming best-two matcher: clock, reset, register writes,
// query and candidate stimulus with random idling, and the final verdict.
// Depends on hbtm_pkg, hamming_best_two_matcher and hbtm_checker.
module tb_hamming_best_two_matcher;

  localparam int HALF_PERIOD     = 6;
  localparam int RESET_CYCLES    = 7;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int HOLD_OFF_CYCLES = 120;
  localparam int SETTLE_CYCLES   = 6;
  localparam int N_SETTINGS      = 9;
  localparam logic [hbtm_pkg::MODE_BITS-1:0] MODE_UNUSED = 2'd3;

  logic                                clk;
  logic                                rst;
  logic                                req_valid;
  logic                                req_stall;
  hbtm_pkg::req_t                      req;
  logic                                res_valid;
  logic                                res_stall;
  hbtm_pkg::res_t                      res;
  logic                                cfg_we;
  logic [hbtm_pkg::CFG_INDEX_BITS-1:0] cfg_index;
  logic [hbtm_pkg::CFG_DATA_BITS-1:0]  cfg_data;
  int                                  fail_count;
  int                                  open_count;
  int                                  result_count;
  int                                  items_sent;
  int                                  settings_used;
  bit                                  hold_off_go;
  bit                                  steady_send;
  logic [hbtm_pkg::DESC_BITS-1:0]      cur_query;

  logic [hbtm_pkg::MODE_BITS-1:0] mode_list[N_SETTINGS] = '{
    hbtm_pkg::MODE_VOCAB, hbtm_pkg::MODE_PROJ, hbtm_pkg::MODE_BEST, hbtm_pkg::MODE_PROJ,
    hbtm_pkg::MODE_VOCAB, MODE_UNUSED, hbtm_pkg::MODE_BEST,
    hbtm_pkg::MODE_PROJ, hbtm_pkg::MODE_VOCAB};
  int thr_list[N_SETTINGS]   = '{50, 100, 0, 256, 256, 100, 511, 30, 0};
  int ratio_list[N_SETTINGS] = '{154, 200, 0, 256, 0, 154, 511, 154, 256};

  initial clk = 1'b0;
  always #HALF_PERIOD clk = ~clk;

  hamming_best_two_matcher u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  hbtm_checker u_check (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .req          (req),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .res          (res),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .open_count   (open_count),
    .result_count (result_count)
  );

  function automatic logic [hbtm_pkg::DESC_BITS-1:0] rand_desc();
    logic [hbtm_pkg::DESC_BITS-1:0] d;
    for (int w = 0; w < hbtm_pkg::DESC_BITS / hbtm_pkg::WORD_BITS; w++) begin
      d[w*hbtm_pkg::WORD_BITS +: hbtm_pkg::WORD_BITS] = {$urandom, $urandom};
    end
    return d;
  endfunction

  // Mask with exactly n bits set; above half, the zeros are placed instead.
  function automatic logic [hbtm_pkg::DESC_BITS-1:0] flip_mask(int n);
    logic [hbtm_pkg::DESC_BITS-1:0] m;
    bit                             invert;
    invert = (n > hbtm_pkg::DESC_BITS / 2);
    if (invert) n = hbtm_pkg::DESC_BITS - n;
    m = '0;
    while ($countones(m) < n) m[$urandom_range(hbtm_pkg::DESC_BITS - 1)] = 1'b1;
    return invert ? ~m : m;
  endfunction

  function automatic hbtm_pkg::req_t make_req(logic op, logic [hbtm_pkg::DESC_BITS-1:0] d,
                                              int idx, int lvl, bit excl, bit fin);
    hbtm_pkg::req_t r;
    r.op            = op;
    r.desc_word0    = d[0*hbtm_pkg::WORD_BITS +: hbtm_pkg::WORD_BITS];
    r.desc_word1    = d[1*hbtm_pkg::WORD_BITS +: hbtm_pkg::WORD_BITS];
    r.desc_word2    = d[2*hbtm_pkg::WORD_BITS +: hbtm_pkg::WORD_BITS];
    r.desc_word3    = d[3*hbtm_pkg::WORD_BITS +: hbtm_pkg::WORD_BITS];
    r.cand_index    = hbtm_pkg::INDEX_BITS'(idx);
    r.cand_level    = hbtm_pkg::LEVEL_BITS'(lvl);
    r.cand_excluded = excl;
    r.last          = fin;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_item(input hbtm_pkg::req_t it);
    int gap;
    gap = steady_send ? 0 : pick_gap();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= it;
    if (it.op == hbtm_pkg::OP_LOAD) begin
      cur_query = {it.desc_word3, it.desc_word2, it.desc_word1, it.desc_word0};
    end
    do @(posedge clk); while (req_stall);
    items_sent++;
  endtask

  task automatic write_regs(input logic [hbtm_pkg::MODE_BITS-1:0] mode, input int thr,
                            input int rat);
    cfg_we    <= 1'b1;
    cfg_index <= hbtm_pkg::CFG_MATCH_MODE;
    cfg_data  <= hbtm_pkg::CFG_DATA_BITS'(mode);
    @(posedge clk);
    cfg_index <= hbtm_pkg::CFG_THRESHOLD;
    cfg_data  <= hbtm_pkg::CFG_DATA_BITS'(thr);
    @(posedge clk);
    cfg_index <= hbtm_pkg::CFG_RATIO;
    cfg_data  <= hbtm_pkg::CFG_DATA_BITS'(rat);
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // Loads and plain candidates leave no result, so the block may still be busy
  // when the last verdict has come back: let it settle before going on.
  task automatic drain();
    req_valid <= 1'b0;
    @(posedge clk);
    while (open_count != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mostly well-formed batches against the current query, with distances bunched
  // near the thresholds; the rest are new queries, noise and batches left open.
  task automatic run_random(input int count);
    int goal;
    int pick;
    int len;
    int base;
    int spread;
    int target_dist;
    bit narrow;
    bit broken;
    goal = items_sent + count;
    while (items_sent < goal) begin
      pick = $urandom_range(99);
      if (pick < 10) begin
        send_item(make_req(hbtm_pkg::OP_LOAD, rand_desc(), $urandom_range(4095),
                           $urandom_range(7), 1'($urandom_range(1)),
                           1'($urandom_range(1))));
      end else if (pick < 18) begin
        send_item(make_req(1'($urandom_range(1)), rand_desc(), $urandom_range(4095),
                           $urandom_range(7), 1'($urandom_range(1)),
                           1'($urandom_range(1))));
      end else begin
        len    = ($urandom_range(9) == 0) ? $urandom_range(7, 14) : $urandom_range(1, 5);
        base   = ($urandom_range(3) == 0) ? $urandom_range(0, hbtm_pkg::DESC_BITS)
                                          : $urandom_range(0, 70);
        spread = $urandom_range(0, 24);
        narrow = 1'($urandom_range(1));
        broken = ($urandom_range(9) == 0);
        for (int k = 0; k < len; k++) begin
          target_dist = base + $urandom_range(0, spread);
          if (target_dist > hbtm_pkg::DESC_BITS) target_dist = hbtm_pkg::DESC_BITS;
          send_item(make_req(hbtm_pkg::OP_CAND, cur_query ^ flip_mask(target_dist),
                             $urandom_range(4095),
                             narrow ? $urandom_range(1) : $urandom_range(7),
                             $urandom_range(9) == 0, (k == len - 1) && !broken));
        end
      end
    end
  endtask

  // Receiver: random stall runs, long free stretches, and one long hold-off.
  initial begin : res_stall_gen
    int run;
    int hold_left;
    bit stalling;
    bit hold_done;
    run       = 0;
    hold_left = 0;
    stalling  = 1'b0;
    hold_done = 1'b0;
    res_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        res_stall <= 1'b1;
      end else if (hold_off_go && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_OFF_CYCLES - 1;
        res_stall <= 1'b1;
      end else begin
        if (run == 0) begin
          stalling = !stalling;
          if (stalling) begin
            run = ($urandom_range(9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
          end else begin
            run = ($urandom_range(4) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
          end
        end
        run--;
        res_stall <= stalling;
      end
    end
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Run stopped after %0d cycles without finishing.", CYCLE_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : stimulus
    logic [hbtm_pkg::DESC_BITS-1:0] q;
    rst           = 1'b1;
    req_valid     = 1'b0;
    req           = '0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    hold_off_go   = 1'b0;
    steady_send   = 1'b0;
    items_sent    = 0;
    settings_used = 0;
    cur_query     = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    write_regs(mode_list[0], thr_list[0], ratio_list[0]);

    // Candidates ahead of any query are measured against the all-zero reset query.
    send_item(make_req(hbtm_pkg::OP_CAND, '0, 0, 0, 1'b0, 1'b0));
    send_item(make_req(hbtm_pkg::OP_CAND, '1, 4095, 7, 1'b0, 1'b1));
    // A query load ignores its last flag.
    send_item(make_req(hbtm_pkg::OP_LOAD, '1, 4095, 7, 1'b1, 1'b1));
    // A batch whose only candidate is excluded counts nothing but still gives a verdict.
    send_item(make_req(hbtm_pkg::OP_CAND, rand_desc(), 123, 5, 1'b1, 1'b1));
    q = rand_desc();
    send_item(make_req(hbtm_pkg::OP_LOAD, q, 0, 0, 1'b0, 1'b0));
    // Equal distances: the second takes second place, the third changes nothing.
    send_item(make_req(hbtm_pkg::OP_CAND, q ^ flip_mask(20), 17, 3, 1'b0, 1'b0));
    send_item(make_req(hbtm_pkg::OP_CAND, q ^ flip_mask(20), 2048, 3, 1'b0, 1'b0));
    send_item(make_req(hbtm_pkg::OP_CAND, q ^ flip_mask(20), 1024, 5, 1'b0, 1'b0));
    send_item(make_req(hbtm_pkg::OP_CAND, q ^ flip_mask(10), 99, 1, 1'b1, 1'b0));
    send_item(make_req(hbtm_pkg::OP_CAND, q ^ flip_mask(30), 100, 2, 1'b1, 1'b1));
    send_item(make_req(hbtm_pkg::OP_CAND, ~q, 4095, 0, 1'b0, 1'b1));
    // Best 3 against second 5 sits just inside the default ratio.
    send_item(make_req(hbtm_pkg::OP_CAND, q ^ flip_mask(5), 2730, 2, 1'b0, 1'b0));
    send_item(make_req(hbtm_pkg::OP_CAND, q ^ flip_mask(40), 1365, 0, 1'b0, 1'b0));
    send_item(make_req(hbtm_pkg::OP_CAND, q ^ flip_mask(3), 1, 2, 1'b0, 1'b1));
    send_item(make_req(hbtm_pkg::OP_CAND, q ^ flip_mask(50), 7, 4, 1'b0, 1'b1));
    send_item(make_req(hbtm_pkg::OP_CAND, q, 8, 6, 1'b0, 1'b1));
    run_random(40);
    drain();

    for (int s = 1; s < N_SETTINGS; s++) begin
      write_regs(mode_list[s], thr_list[s], ratio_list[s]);
      if (s == 1) begin
        // The sender keeps offering items while the receiver holds off.
        steady_send = 1'b1;
        hold_off_go <= 1'b1;
      end else begin
        steady_send = ($urandom_range(3) == 0);
      end
      run_random(45);
      steady_send = 1'b0;
      drain();
    end

    $display("Summary: %0d items under %0d register settings, all four modes,",
             items_sent, settings_used);
    $display("Summary: thresholds and ratios 0 to 511, %0d verdicts compared, %0d failures.",
             result_count, fail_count);
    if (fail_count == 0 && open_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
